### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the sort engine rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define QS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// antecedent implies consequent in the following cycle
`define QS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define QS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define QS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

### sv/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg
// shared constants for the quicksort engine
// ----------------------------------------------------------------------------
package qs_pkg;

  // element width, fixed by the data format
  localparam int DATA_W = 32;

  // default number of elements held per set
  localparam int CAPACITY_DEF = 16;

endpackage

### sv/qs_ram.sv
// ----------------------------------------------------------------------------
// qs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module qs_ram #(
  parameter int WIDTH = qs_pkg::DATA_W,
  parameter int DEPTH = qs_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/qs_ctrl.sv
// ----------------------------------------------------------------------------
// qs_ctrl
// load, partition and emit sequencer for the quicksort engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qs_ctrl #(
  parameter int CAPACITY = qs_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          is_last,
  output logic                          busy,
  output logic                          strobe,
  output logic                          last_out,
  output logic                          overflow,
  // element store port
  output logic                          e_we,
  output logic [$clog2(CAPACITY)-1:0]   e_waddr,
  output logic [qs_pkg::DATA_W-1:0]     e_wdata,
  output logic                          e_re,
  output logic [$clog2(CAPACITY)-1:0]   e_raddr,
  input  logic [qs_pkg::DATA_W-1:0]     e_rdata,
  input  logic [qs_pkg::DATA_W-1:0]     value,
  // range stack port
  output logic                          s_we,
  output logic [$clog2(CAPACITY)-1:0]   s_waddr,
  output logic [2*$clog2(CAPACITY)-1:0] s_wdata,
  output logic                          s_re,
  output logic [$clog2(CAPACITY)-1:0]   s_raddr,
  input  logic [2*$clog2(CAPACITY)-1:0] s_rdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = 2 * IW;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] TWO_C = CW'(2);
  localparam logic [IW:0]   ONE_X = (IW + 1)'(1);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_RDMID  = 15'b000000000000010,
    ST_RDLO   = 15'b000000000000100,
    ST_SWAP0  = 15'b000000000001000,
    ST_WRLO   = 15'b000000000010000,
    ST_SCAN   = 15'b000000000100000,
    ST_SWPA   = 15'b000000001000000,
    ST_SWPB   = 15'b000000010000000,
    ST_FINRD  = 15'b000000100000000,
    ST_FINWLO = 15'b000001000000000,
    ST_FINWM  = 15'b000010000000000,
    ST_PUSHL  = 15'b000100000000000,
    ST_POP    = 15'b001000000000000,
    ST_POPW   = 15'b010000000000000,
    ST_EMIT   = 15'b100000000000000
  } state_t;

  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic                      ovf_seen, ovf_seen_next;
  logic [CW-1:0]             sp, sp_next;
  logic [IW-1:0]             lo, lo_next;
  logic [IW-1:0]             hi, hi_next;
  logic [IW-1:0]             m, m_next;
  logic [IW-1:0]             k, k_next;
  logic [IW-1:0]             idx, idx_next;
  logic [qs_pkg::DATA_W-1:0] pivot, pivot_next;
  logic [qs_pkg::DATA_W-1:0] tmp, tmp_next;
  logic                      strobe_r, strobe_next;
  logic                      last_r, last_next;
  logic                      ovf_r, ovf_next;

  logic [IW-1:0] mid;
  logic          less;
  logic          push_r;
  logic          push_l;
  logic [CW-1:0] n_load;
  logic          room;

  assign mid    = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign less   = $signed(e_rdata) < $signed(pivot);
  assign room   = count < CAP_C;
  assign n_load = room ? count + 1'b1 : count;
  // right part pushed first, left part popped first
  assign push_r = (({1'b0, m} + ONE_X) < {1'b0, hi}) && (sp < CAP_C);
  assign push_l = (({1'b0, lo} + ONE_X) < {1'b0, m}) && (sp < CAP_C);

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_seen_next = ovf_seen;
    sp_next       = sp;
    lo_next       = lo;
    hi_next       = hi;
    m_next        = m;
    k_next        = k;
    idx_next      = idx;
    pivot_next    = pivot;
    tmp_next      = tmp;
    strobe_next   = 1'b0;
    last_next     = last_r;
    ovf_next      = ovf_r;
    e_we          = 1'b0;
    e_waddr       = '0;
    e_wdata       = value;
    e_re          = 1'b0;
    e_raddr       = '0;
    s_we          = 1'b0;
    s_waddr       = sp[IW-1:0];
    s_wdata       = {IW'(m + 1'b1), hi};
    s_re          = 1'b0;
    s_raddr       = IW'(sp - 1'b1);

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (room) begin
            e_we       = 1'b1;
            e_waddr    = count[IW-1:0];
            count_next = count + 1'b1;
          end else begin
            ovf_seen_next = 1'b1;
          end
          if (is_last) begin
            if (n_load >= TWO_C) begin
              lo_next    = '0;
              hi_next    = IW'(n_load - 1'b1);
              state_next = ST_RDMID;
            end else begin
              idx_next   = '0;
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_RDMID: begin
        e_re       = 1'b1;
        e_raddr    = mid;
        state_next = ST_RDLO;
      end
      ST_RDLO: begin
        pivot_next = e_rdata;
        e_re       = 1'b1;
        e_raddr    = lo;
        state_next = ST_SWAP0;
      end
      ST_SWAP0: begin
        // old front element goes to the middle slot
        e_we       = 1'b1;
        e_waddr    = mid;
        e_wdata    = e_rdata;
        state_next = ST_WRLO;
      end
      ST_WRLO: begin
        e_we       = 1'b1;
        e_waddr    = lo;
        e_wdata    = pivot;
        m_next     = lo;
        k_next     = lo + 1'b1;
        e_re       = 1'b1;
        e_raddr    = lo + 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (less && ((m + 1'b1) != k)) begin
          m_next     = m + 1'b1;
          tmp_next   = e_rdata;
          e_re       = 1'b1;
          e_raddr    = m + 1'b1;
          state_next = ST_SWPA;
        end else begin
          if (less) begin
            m_next = m + 1'b1;
          end
          if (k == hi) begin
            state_next = ST_FINRD;
          end else begin
            k_next  = k + 1'b1;
            e_re    = 1'b1;
            e_raddr = k + 1'b1;
          end
        end
      end
      ST_SWPA: begin
        e_we       = 1'b1;
        e_waddr    = k;
        e_wdata    = e_rdata;
        state_next = ST_SWPB;
      end
      ST_SWPB: begin
        e_we    = 1'b1;
        e_waddr = m;
        e_wdata = tmp;
        if (k == hi) begin
          state_next = ST_FINRD;
        end else begin
          k_next     = k + 1'b1;
          e_re       = 1'b1;
          e_raddr    = k + 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_FINRD: begin
        e_re       = 1'b1;
        e_raddr    = m;
        state_next = ST_FINWLO;
      end
      ST_FINWLO: begin
        e_we       = 1'b1;
        e_waddr    = lo;
        e_wdata    = e_rdata;
        state_next = ST_FINWM;
      end
      ST_FINWM: begin
        e_we    = 1'b1;
        e_waddr = m;
        e_wdata = pivot;
        if (push_r) begin
          s_we    = 1'b1;
          sp_next = sp + 1'b1;
        end
        state_next = ST_PUSHL;
      end
      ST_PUSHL: begin
        s_wdata = {lo, IW'(m - 1'b1)};
        if (push_l) begin
          s_we    = 1'b1;
          sp_next = sp + 1'b1;
        end
        if (sp_next != '0) begin
          state_next = ST_POP;
        end else begin
          idx_next   = '0;
          state_next = ST_EMIT;
        end
      end
      ST_POP: begin
        s_re       = 1'b1;
        sp_next    = sp - 1'b1;
        state_next = ST_POPW;
      end
      ST_POPW: begin
        lo_next    = s_rdata[SW-1:IW];
        hi_next    = s_rdata[IW-1:0];
        state_next = ST_RDMID;
      end
      ST_EMIT: begin
        e_re        = 1'b1;
        e_raddr     = idx;
        strobe_next = 1'b1;
        ovf_next    = ovf_seen;
        last_next   = (CW'(idx) == (count - 1'b1));
        if (CW'(idx) == (count - 1'b1)) begin
          count_next    = '0;
          ovf_seen_next = 1'b0;
          sp_next       = '0;
          state_next    = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      sp       <= '0;
      strobe_r <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf_seen <= ovf_seen_next;
      sp       <= sp_next;
      strobe_r <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    m      <= m_next;
    k      <= k_next;
    idx    <= idx_next;
    pivot  <= pivot_next;
    tmp    <= tmp_next;
    last_r <= last_next;
    ovf_r  <= ovf_next;
  end

  assign busy     = (state != ST_IDLE);
  assign strobe   = strobe_r;
  assign last_out = last_r;
  assign overflow = ovf_r;

  // the sequence never reads and writes the same element in one cycle
  `QS_ASSERT_IMPLIES(a_no_rw_clash, clk, rst, e_we && e_re, e_waddr != e_raddr)
  // scan keeps the boundary below the cursor and inside the range
  `QS_ASSERT_IMPLIES(a_scan_order, clk, rst, state == ST_SCAN, (m < k) && (k <= hi))
  // range stack is empty whenever the engine is idle
  `QS_ASSERT_IMPLIES(a_idle_stack, clk, rst, state == ST_IDLE, sp == '0)
  // a result only follows an emit cycle
  `QS_ASSERT_IMPLIES(a_strobe_src, clk, rst, strobe, $past(state == ST_EMIT))
  // the final result of a set ends the burst
  `QS_ASSERT_NEXT(a_burst_end, clk, rst, strobe && last_out, !strobe)

endmodule

### sv/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine
// in-place quicksort of a set of signed 32-bit values held in on-chip ram
// ----------------------------------------------------------------------------
// items are loaded one per cycle whenever start is high and busy is low; up to
// CAPACITY values are kept and later ones are dropped (overflow is then set on
// every result of that set). the item with is_last high closes the set and
// raises busy: the set is sorted in place in ascending signed order, then
// every stored value is sent out, one per cycle, each marked by a one-cycle
// strobe. the receiver cannot stall, so results must be taken as they come;
// last_out flags the final one. busy drops in the cycle that carries the last
// result, so the next set may start loading at once. each partitioned range
// puts its middle value as pivot at the front, is scanned with one compare
// per element after it, moves the pivot to its final slot and pushes the
// sub-ranges of two or more; all but the first, full range are popped from
// the stack. swaps cost extra states, as the element ram has one read and
// one write port and a registered read. there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module quicksort_engine #(
  parameter int CAPACITY = qs_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // load side
  input  logic                             start,
  output logic                             busy,
  input  logic signed [qs_pkg::DATA_W-1:0] value,
  input  logic                             is_last,
  // result side, one transfer per strobe cycle
  output logic                             strobe,
  output logic signed [qs_pkg::DATA_W-1:0] sorted_value,
  output logic                             last_out,
  output logic                             overflow
);

  localparam int IW = $clog2(CAPACITY);

  // element store port
  logic                      e_we;
  logic [IW-1:0]             e_waddr;
  logic [qs_pkg::DATA_W-1:0] e_wdata;
  logic                      e_re;
  logic [IW-1:0]             e_raddr;
  logic [qs_pkg::DATA_W-1:0] e_rdata;

  // range stack port, entries are {lo, hi}
  logic                      s_we;
  logic [IW-1:0]             s_waddr;
  logic [2*IW-1:0]           s_wdata;
  logic                      s_re;
  logic [IW-1:0]             s_raddr;
  logic [2*IW-1:0]           s_rdata;

  // sequencer: load, partition loop, stack handling and output burst
  qs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_last  (is_last),
    .busy     (busy),
    .strobe   (strobe),
    .last_out (last_out),
    .overflow (overflow),
    .e_we     (e_we),
    .e_waddr  (e_waddr),
    .e_wdata  (e_wdata),
    .e_re     (e_re),
    .e_raddr  (e_raddr),
    .e_rdata  (e_rdata),
    .value    (value),
    .s_we     (s_we),
    .s_waddr  (s_waddr),
    .s_wdata  (s_wdata),
    .s_re     (s_re),
    .s_raddr  (s_raddr),
    .s_rdata  (s_rdata)
  );

  // element store, also feeds the result port directly from its read register
  qs_ram #(
    .WIDTH (qs_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // pending ranges in place of recursion
  qs_ram #(
    .WIDTH (2 * IW),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign sorted_value = $signed(e_rdata);

endmodule
